>>> rtl/playfair_cipher_encryptor_assert.svh
// ----------------------------------------------------------------------------
// Playfair encryptor assertion macros
// Concurrent assertion helpers used by the datapath of the encryptor.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_CIPHER_ENCRYPTOR_ASSERT_SVH
`define PLAYFAIR_CIPHER_ENCRYPTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/pfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Playfair encryptor package
// Types, constants and small lookup functions shared by the encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam int SQUARE_SIDE = 5;
	localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
	localparam int LETTERS     = 26;
	localparam int CODE_W      = $clog2(LETTERS);
	localparam int CELL_W      = $clog2(CELLS);
	localparam int SIDE_W      = $clog2(SQUARE_SIDE);

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [SIDE_W-1:0] side_t;

	localparam code_t LETTER_I = code_t'(8);
	localparam code_t LETTER_J = code_t'(9);
	localparam code_t LETTER_X = code_t'(23);

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

	typedef enum logic [1:0] {
		OP_KEY      = 2'd0,
		OP_KEY_DONE = 2'd1,
		OP_MSG      = 2'd2,
		OP_FLUSH    = 2'd3
	} opcode_t;

	typedef struct packed {
		logic take_item;
		logic fill_step;
		logic fill_done;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic fill_op;
		logic makes_pair;
		logic fill_last;
		logic out_free;
	} status_t;

	function automatic logic is_letter(input logic [7:0] ch);
		return ((ch >= ASCII_UPPER_A) && (ch <= ASCII_UPPER_Z)) ||
			((ch >= ASCII_LOWER_A) && (ch <= ASCII_LOWER_Z));
	endfunction

	function automatic code_t fold_code(input logic [7:0] ch);
		logic [7:0] d;
		code_t      c;
		if ((ch >= ASCII_LOWER_A) && (ch <= ASCII_LOWER_Z)) begin
			d = ch - ASCII_LOWER_A;
		end else begin
			d = ch - ASCII_UPPER_A;
		end
		c = d[CODE_W-1:0];
		if (c == LETTER_J) begin
			c = LETTER_I;
		end
		return c;
	endfunction

	function automatic side_t row_of(input cell_t p);
		side_t r;
		r = '0;
		for (int k = 1; k < SQUARE_SIDE; k++) begin
			if (int'(p) >= k * SQUARE_SIDE) begin
				r = side_t'(k);
			end
		end
		return r;
	endfunction

	function automatic side_t col_of(input cell_t p);
		return side_t'(int'(p) - int'(row_of(p)) * SQUARE_SIDE);
	endfunction

	function automatic side_t next_of(input side_t i);
		return (int'(i) == SQUARE_SIDE - 1) ? side_t'(0) : side_t'(int'(i) + 1);
	endfunction

	function automatic cell_t cell_at(input side_t r, input side_t c);
		return cell_t'(int'(r) * SQUARE_SIDE + int'(c));
	endfunction

endpackage
`default_nettype wire

>>> rtl/pfe_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Playfair encryptor input channel
// Valid/ready channel carrying one opcode-tagged character per beat.
// ----------------------------------------------------------------------------
interface pfe_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] character;

	modport source (output valid, output opcode, output character, input ready);
	modport sink (input valid, input opcode, input character, output ready);
endinterface
`default_nettype wire

>>> rtl/pfe_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Playfair encryptor output channel
// Valid/ready channel carrying one ciphertext letter per beat.
// ----------------------------------------------------------------------------
interface pfe_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] cipher_letter;
	logic       last_of_run;

	modport source (output valid, output cipher_letter, output last_of_run, input ready);
	modport sink (input valid, input cipher_letter, input last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/playfair_cipher_encryptor.sv
// A key letter or an unpaired message letter is handled on acceptance. Key done
// starts the alphabet walk, which steps one letter per cycle. A completed pair
// passes two registered memory reads and waits for a free output register, then
// leaves as two beats, one per cycle while the receiver is ready.
// The next item is accepted while the previous pair is still draining.
// Reset clears the used marks, fill count, key-ready flag, pending letter and output.
`default_nettype none
// ----------------------------------------------------------------------------
// Playfair cipher encryptor
// Builds the key square from key letters and enciphers message letter pairs.
// ----------------------------------------------------------------------------
module playfair_cipher_encryptor (
	input  wire logic clk,
	input  wire logic arst_n,
	pfe_in_if.sink    items,
	pfe_out_if.source results
);

	pfe_pkg::cmd_t    cmd;
	pfe_pkg::status_t status;

	pfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.status   (status),
		.cmd      (cmd)
	);

	pfe_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (items.opcode),
		.character     (items.character),
		.status        (status),
		.out_valid     (results.valid),
		.out_ready     (results.ready),
		.cipher_letter (results.cipher_letter),
		.last_of_run   (results.last_of_run)
	);

endmodule
`default_nettype wire

>>> rtl/pfe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Playfair encryptor RAM
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pfe_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

>>> rtl/pfe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Playfair encryptor controller
// Sequences item intake, the alphabet fill walk and pair encipherment.
// ----------------------------------------------------------------------------
module pfe_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire pfe_pkg::status_t status,
	output pfe_pkg::cmd_t        cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_FILL   = 5'b00010,
		ST_RD_POS = 5'b00100,
		ST_RD_SQ  = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   take;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd.take_item = take;
		cmd.fill_step = (state_q == ST_FILL);
		cmd.fill_done = (state_q == ST_FILL) && status.fill_last;
		cmd.load_out  = (state_q == ST_EMIT) && status.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && status.fill_op) begin
					state_d = ST_FILL;
				end else if (take && status.makes_pair) begin
					state_d = ST_RD_POS;
				end
			end
			ST_FILL: begin
				if (status.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD_POS: begin
				state_d = ST_RD_SQ;
			end
			ST_RD_SQ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/pfe_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Playfair encryptor datapath
// Key square storage, letter pairing, pair lookup and the output buffer.
// ----------------------------------------------------------------------------
`include "playfair_cipher_encryptor_assert.svh"

module pfe_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pfe_pkg::cmd_t    cmd,
	input  wire logic [1:0]       opcode,
	input  wire logic [7:0]       character,
	output pfe_pkg::status_t      status,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [6:0]       cipher_letter,
	output logic                  last_of_run
);

	pfe_pkg::opcode_t op;
	logic             letter_ok;
	pfe_pkg::code_t   code;

	logic [pfe_pkg::LETTERS-1:0] used_q;
	pfe_pkg::cell_t              fill_q;
	logic                        key_ready_q;
	pfe_pkg::code_t              pend_q;
	logic                        pend_v_q;
	pfe_pkg::code_t              walk_q;
	pfe_pkg::code_t              a_q;
	pfe_pkg::code_t              b_q;
	logic [1:0]                  out_cnt_q;
	logic [6:0]                  let0_q;
	logic [6:0]                  let1_q;

	logic                        key_place;
	logic                        fill_place;
	logic                        place;
	logic                        store_upd;
	pfe_pkg::code_t              place_code;
	logic [pfe_pkg::LETTERS-1:0] base_used;
	pfe_pkg::cell_t              base_fill;
	logic                        msg_go;
	pfe_pkg::code_t              pair_b;

	pfe_pkg::cell_t pa;
	pfe_pkg::cell_t pb;
	pfe_pkg::side_t r1;
	pfe_pkg::side_t c1;
	pfe_pkg::side_t r2;
	pfe_pkg::side_t c2;
	pfe_pkg::cell_t xa;
	pfe_pkg::cell_t ya;
	pfe_pkg::code_t xl;
	pfe_pkg::code_t yl;

	assign op        = pfe_pkg::opcode_t'(opcode);
	assign letter_ok = pfe_pkg::is_letter(character);
	assign code      = pfe_pkg::fold_code(character);

	// A key letter after a finished square starts a new key from scratch.
	assign key_place  = cmd.take_item && (op == pfe_pkg::OP_KEY) && letter_ok;
	assign fill_place = cmd.fill_step && (walk_q != pfe_pkg::LETTER_J);
	assign store_upd  = key_place || cmd.fill_step;
	assign place_code = cmd.fill_step ? walk_q : code;
	assign base_used  = (key_place && key_ready_q) ? '0 : used_q;
	assign base_fill  = (key_place && key_ready_q) ? '0 : fill_q;
	assign place      = (key_place || fill_place) && !base_used[place_code] &&
		(base_fill < pfe_pkg::cell_t'(pfe_pkg::CELLS));

	assign msg_go = key_ready_q && pend_v_q &&
		(((op == pfe_pkg::OP_MSG) && letter_ok) || (op == pfe_pkg::OP_FLUSH));
	assign pair_b = ((op == pfe_pkg::OP_FLUSH) || (pend_q == code)) ?
		pfe_pkg::LETTER_X : code;

	always_comb begin
		status.fill_op    = (op == pfe_pkg::OP_KEY_DONE);
		status.makes_pair = msg_go;
		status.fill_last  = (walk_q == pfe_pkg::code_t'(pfe_pkg::LETTERS - 1));
		status.out_free   = (out_cnt_q == 2'd0);
	end

	pfe_ram #(
		.WIDTH (pfe_pkg::CELL_W),
		.DEPTH (pfe_pkg::LETTERS)
	) u_pos_ram (
		.clk     (clk),
		.we      (place),
		.waddr   (place_code),
		.wdata   (base_fill),
		.raddr_a (a_q),
		.raddr_b (b_q),
		.rdata_a (pa),
		.rdata_b (pb)
	);

	assign r1 = pfe_pkg::row_of(pa);
	assign c1 = pfe_pkg::col_of(pa);
	assign r2 = pfe_pkg::row_of(pb);
	assign c2 = pfe_pkg::col_of(pb);

	always_comb begin
		if (r1 == r2) begin
			xa = pfe_pkg::cell_at(r1, pfe_pkg::next_of(c1));
			ya = pfe_pkg::cell_at(r2, pfe_pkg::next_of(c2));
		end else if (c1 == c2) begin
			xa = pfe_pkg::cell_at(pfe_pkg::next_of(r1), c1);
			ya = pfe_pkg::cell_at(pfe_pkg::next_of(r2), c2);
		end else begin
			xa = pfe_pkg::cell_at(r1, c2);
			ya = pfe_pkg::cell_at(r2, c1);
		end
	end

	pfe_ram #(
		.WIDTH (pfe_pkg::CODE_W),
		.DEPTH (pfe_pkg::CELLS)
	) u_square_ram (
		.clk     (clk),
		.we      (place),
		.waddr   (base_fill),
		.wdata   (place_code),
		.raddr_a (xa),
		.raddr_b (ya),
		.rdata_a (xl),
		.rdata_b (yl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			fill_q      <= '0;
			key_ready_q <= 1'b0;
			pend_q      <= '0;
			pend_v_q    <= 1'b0;
			walk_q      <= '0;
			out_cnt_q   <= 2'd0;
		end else begin
			if (store_upd) begin
				used_q <= base_used |
					(place ? (pfe_pkg::LETTERS'(1) << place_code) : '0);
				fill_q <= base_fill + pfe_pkg::cell_t'(place);
			end
			if (cmd.fill_step) begin
				walk_q <= walk_q + pfe_pkg::code_t'(1);
			end
			if (cmd.fill_done) begin
				key_ready_q <= 1'b1;
			end
			if (cmd.take_item) begin
				case (op)
					pfe_pkg::OP_KEY: begin
						if (letter_ok && key_ready_q) begin
							key_ready_q <= 1'b0;
							pend_v_q    <= 1'b0;
							pend_q      <= '0;
						end
					end
					pfe_pkg::OP_KEY_DONE: begin
						walk_q <= '0;
					end
					pfe_pkg::OP_MSG: begin
						if (key_ready_q && letter_ok) begin
							if (!pend_v_q) begin
								pend_q   <= code;
								pend_v_q <= 1'b1;
							end else if (pend_q != code) begin
								pend_v_q <= 1'b0;
							end
						end
					end
					pfe_pkg::OP_FLUSH: begin
						if (key_ready_q) begin
							pend_v_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_out) begin
				out_cnt_q <= 2'd2;
			end else if (out_valid && out_ready) begin
				out_cnt_q <= out_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item && msg_go) begin
			a_q <= pend_q;
			b_q <= pair_b;
		end
		if (cmd.load_out) begin
			let0_q <= 7'd65 + {2'b00, xl};
			let1_q <= 7'd65 + {2'b00, yl};
		end
	end

	assign out_valid     = (out_cnt_q != 2'd0);
	assign cipher_letter = (out_cnt_q == 2'd2) ? let0_q : let1_q;
	assign last_of_run   = (out_cnt_q == 2'd1);

	`PFE_ASSERT_IMPL(a_load_when_free, clk, arst_n, cmd.load_out, out_cnt_q == 2'd0, "Output buffer overwritten while letters still wait.")
	`PFE_ASSERT_NEXT(a_load_gives_pair, clk, arst_n, cmd.load_out, out_cnt_q == 2'd2, "Loaded pair does not show two letters.")
	`PFE_ASSERT_IMPL(a_ready_means_full, clk, arst_n, key_ready_q, fill_q == pfe_pkg::cell_t'(pfe_pkg::CELLS), "Key square marked ready but not full.")
	`PFE_ASSERT_IMPL(a_fill_bound, clk, arst_n, 1'b1, fill_q <= pfe_pkg::cell_t'(pfe_pkg::CELLS), "Fill count ran past the square.")

endmodule
`default_nettype wire

>>> sim/tb_playfair_cipher_encryptor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher encryptor testbench
// Drives key and message characters through the input channel and compares
// every ciphertext beat with a behavioral Playfair model held in this file.
// A short directed table comes first. Random key and message sessions follow
// under several idle and stall patterns, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb_playfair_cipher_encryptor;

	localparam int PHASE_ITEMS    = 125;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PRINT_LIMIT    = 40;
	localparam int NO_LETTER      = pfe_pkg::LETTERS;

	typedef struct packed {
		logic [6:0] letter;
		logic       last;
	} cipher_beat_t;

	typedef struct packed {
		pfe_pkg::opcode_t op;
		logic [7:0]       ch;
		int               n_typed;
		logic [6:0]       first;
		logic [6:0]       second;
	} stim_row_t;

	// Rows with n_typed of -1 are checked against the model alone.
	localparam stim_row_t DIRECTED [27] = '{
		'{pfe_pkg::OP_MSG,      "a",   0, 7'd0,    7'd0},
		'{pfe_pkg::OP_FLUSH,    8'h00, 0, 7'd0,    7'd0},
		'{pfe_pkg::OP_KEY_DONE, 8'hFF, 0, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      "A",   0, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      "z",   2, 7'("E"), 7'("V")},
		'{pfe_pkg::OP_FLUSH,    8'h00, 0, 7'd0,    7'd0},
		'{pfe_pkg::OP_KEY,      8'hFF, 0, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      8'h00, 0, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      8'h80, 0, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      "I",   0, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      "j",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      "X",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      "X",   0, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      "x",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_FLUSH,    8'h7F, -1, 7'd0,   7'd0},
		'{pfe_pkg::OP_KEY,      "p",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_KEY,      "L",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_KEY,      "a",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_KEY,      "Y",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_KEY,      "A",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_KEY,      "J",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_KEY,      "i",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      "Q",   0, 7'd0,    7'd0},
		'{pfe_pkg::OP_KEY_DONE, 8'h00, -1, 7'd0,   7'd0},
		'{pfe_pkg::OP_KEY_DONE, 8'h55, 0, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      "H",  -1, 7'd0,    7'd0},
		'{pfe_pkg::OP_MSG,      "E",  -1, 7'd0,    7'd0}
	};

	logic clk;
	logic arst_n;

	pfe_in_if  items_if ();
	pfe_out_if results_if ();

	playfair_cipher_encryptor u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_if),
		.results(results_if)
	);

	// Model state of the key square and the pairing logic.
	pfe_pkg::code_t sq_cell [pfe_pkg::CELLS];
	pfe_pkg::cell_t pos_of [pfe_pkg::LETTERS];
	bit             used [pfe_pkg::LETTERS];
	int             fills;
	bit             sq_ready;
	pfe_pkg::code_t held;
	bit             held_valid;

	cipher_beat_t cipher_due [$];
	int           mismatches;
	int           accepted_items;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           burst_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
	endtask

	function automatic int letter_code(input logic [7:0] ch);
		int c;
		c = int'(ch);
		if (c >= "a" && c <= "z") begin
			c = c - "a" + "A";
		end
		if (c < "A" || c > "Z") begin
			return NO_LETTER;
		end
		c = c - "A";
		if (c == int'(pfe_pkg::LETTER_J)) begin
			c = int'(pfe_pkg::LETTER_I);
		end
		return c;
	endfunction

	function automatic logic [7:0] random_letter();
		logic [7:0] c;
		c = 8'("A") + 8'($urandom_range(25));
		if ($urandom_range(1) == 1) begin
			c = c + 8'h20;
		end
		return c;
	endfunction

	task automatic take_letter(input int code);
		if (used[code] || fills >= pfe_pkg::CELLS) begin
			return;
		end
		sq_cell[fills] = pfe_pkg::code_t'(code);
		pos_of[code] = pfe_pkg::cell_t'(fills);
		used[code] = 1'b1;
		fills++;
	endtask

	task automatic cipher_pair(input int a, input int b, output cipher_beat_t x,
			output cipher_beat_t y);
		int pa, pb, r1, c1, r2, c2, xa, yb, side;
		side = pfe_pkg::SQUARE_SIDE;
		pa = int'(pos_of[a]);
		pb = int'(pos_of[b]);
		r1 = pa / side;
		c1 = pa % side;
		r2 = pb / side;
		c2 = pb % side;
		if (r1 == r2) begin
			xa = int'(sq_cell[r1 * side + (c1 + 1) % side]);
			yb = int'(sq_cell[r2 * side + (c2 + 1) % side]);
		end else if (c1 == c2) begin
			xa = int'(sq_cell[((r1 + 1) % side) * side + c1]);
			yb = int'(sq_cell[((r2 + 1) % side) * side + c2]);
		end else begin
			xa = int'(sq_cell[r1 * side + c2]);
			yb = int'(sq_cell[r2 * side + c1]);
		end
		x = '{7'("A" + xa), 1'b0};
		y = '{7'("A" + yb), 1'b1};
	endtask

	task automatic encrypt_item(input pfe_pkg::opcode_t op, input logic [7:0] ch,
			output cipher_beat_t b0, output cipher_beat_t b1, output int n,
			output bit ignored);
		int code;
		code = letter_code(ch);
		n = 0;
		ignored = 1'b0;
		b0 = '0;
		b1 = '0;
		case (op)
			pfe_pkg::OP_KEY: begin
				if (code == NO_LETTER) begin
					ignored = 1'b1;
				end else begin
					if (sq_ready) begin
						foreach (used[k]) used[k] = 1'b0;
						fills = 0;
						sq_ready = 1'b0;
						held_valid = 1'b0;
						held = '0;
					end
					take_letter(code);
				end
			end
			pfe_pkg::OP_KEY_DONE: begin
				for (int k = 0; k < pfe_pkg::LETTERS; k++) begin
					if (k != int'(pfe_pkg::LETTER_J)) begin
						take_letter(k);
					end
				end
				sq_ready = 1'b1;
			end
			pfe_pkg::OP_MSG: begin
				if (!sq_ready || code == NO_LETTER) begin
					ignored = 1'b1;
				end else if (!held_valid) begin
					held = pfe_pkg::code_t'(code);
					held_valid = 1'b1;
				end else if (int'(held) == code) begin
					cipher_pair(code, int'(pfe_pkg::LETTER_X), b0, b1);
					n = 2;
				end else begin
					held_valid = 1'b0;
					cipher_pair(int'(held), code, b0, b1);
					n = 2;
				end
			end
			default: begin
				if (!sq_ready || !held_valid) begin
					ignored = 1'b1;
				end else begin
					held_valid = 1'b0;
					cipher_pair(int'(held), int'(pfe_pkg::LETTER_X), b0, b1);
					n = 2;
				end
			end
		endcase
	endtask

	task automatic send_item(input pfe_pkg::opcode_t op, input logic [7:0] ch,
			input int n_typed, input logic [6:0] t0, input logic [6:0] t1);
		cipher_beat_t b0, b1;
		int           n;
		bit           ignored;
		while ($urandom_range(99) < send_idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid     <= 1'b1;
		items_if.opcode    <= op;
		items_if.character <= ch;
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		encrypt_item(op, ch, b0, b1, n, ignored);
		if (n_typed >= 0) begin
			n = n_typed;
			b0 = '{t0, 1'b0};
			b1 = '{t1, 1'b1};
		end
		if (n > 0) cipher_due = {cipher_due, b0};
		if (n > 1) cipher_due = {cipher_due, b1};
		if (!ignored) accepted_items++;
	endtask

	task automatic run_session();
		logic [7:0] ch, prev;
		int         len, pick;
		if (!sq_ready || $urandom_range(3) == 0) begin
			len = $urandom_range(14);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(99) < 3) begin
					send_item(pfe_pkg::opcode_t'($urandom_range(3)),
						8'($urandom_range(255)), -1, 0, 0);
				end
				ch = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : random_letter();
				send_item(pfe_pkg::OP_KEY, ch, -1, 0, 0);
			end
			send_item(pfe_pkg::OP_KEY_DONE, 8'($urandom_range(255)), -1, 0, 0);
			if ($urandom_range(9) == 0) begin
				send_item(pfe_pkg::OP_KEY_DONE, 8'($urandom_range(255)), -1, 0, 0);
			end
		end
		len = $urandom_range(1, 24);
		prev = random_letter();
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < 3) begin
				send_item(pfe_pkg::opcode_t'($urandom_range(3)),
					8'($urandom_range(255)), -1, 0, 0);
			end
			pick = $urandom_range(99);
			if (pick < 8) begin
				ch = 8'($urandom_range(255));
			end else if (pick < 22) begin
				ch = prev ^ (8'($urandom_range(1)) << 5);
			end else if (pick < 27) begin
				ch = ($urandom_range(1) == 1) ? 8'("J") : 8'("i");
			end else begin
				ch = random_letter();
			end
			send_item(pfe_pkg::OP_MSG, ch, -1, 0, 0);
			prev = ch;
		end
		if ($urandom_range(9) < 7) begin
			send_item(pfe_pkg::OP_FLUSH, 8'($urandom_range(255)), -1, 0, 0);
		end
	endtask

	initial begin
		int hold_left;
		int burst_seen;
		hold_left = 0;
		burst_seen = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (burst_req != burst_seen) begin
				burst_seen = burst_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cipher_beat_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (cipher_due.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, letter %0h last %0b",
					results_if.cipher_letter, results_if.last_of_run));
			end else begin
				want = cipher_due.pop_front();
				if (results_if.cipher_letter !== want.letter) begin
					report_mismatch($sformatf("cipher_letter %0h, expected %0h",
						results_if.cipher_letter, want.letter));
				end
				if (results_if.last_of_run !== want.last) begin
					report_mismatch($sformatf("last_of_run %0b, expected %0b",
						results_if.last_of_run, want.last));
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		mismatches = 0;
		accepted_items = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		burst_req = 0;
		fills = 0;
		sq_ready = 1'b0;
		held = '0;
		held_valid = 1'b0;
		foreach (used[k]) used[k] = 1'b0;
		arst_n = 1'b0;
		items_if.valid     <= 1'b0;
		items_if.opcode    <= pfe_pkg::OP_KEY;
		items_if.character <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[r]) begin
			send_item(DIRECTED[r].op, DIRECTED[r].ch, DIRECTED[r].n_typed,
				DIRECTED[r].first, DIRECTED[r].second);
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			// The output side holds off while the sender keeps offering beats.
			if (phase == 0) burst_req++;
			accepted_items = 0;
			while (accepted_items < PHASE_ITEMS) run_session();
			items_if.valid <= 1'b0;
			while (cipher_due.size() != 0) @(posedge clk);
			@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (cipher_due.size() != 0) begin
			report_mismatch($sformatf("%0d beats never arrived", cipher_due.size()));
		end
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/pfe_pkg.sv
rtl/pfe_in_if.sv
rtl/pfe_out_if.sv
rtl/pfe_ram.sv
rtl/pfe_ctrl.sv
rtl/pfe_datapath.sv
rtl/playfair_cipher_encryptor.sv
sim/tb_playfair_cipher_encryptor.sv
